// ===== src/scq_pkg.sv =====
// scq_pkg: shared types, constants and key maps for the scan code queue
// no dependencies; used by scq_xlate, scq_outbuf and scan_code_to_ascii_queue

package scq_pkg;

   localparam int RING_DEPTH_DEF  = 64;
   localparam int MAP_ENTRIES_DEF = 58;
   localparam int MAP_LEN         = 58;

   // item kinds
   localparam logic FUNC_SCAN = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // scan codes, set 1
   localparam logic [7:0] SC_PREFIX = 8'hE0;
   localparam logic [7:0] SC_ESCKEY = 8'h01;
   localparam logic [7:0] SC_CAPS   = 8'h3A;
   localparam logic [7:0] SC_LSHIFT = 8'h2A;
   localparam logic [7:0] SC_RSHIFT = 8'h36;
   localparam logic [7:0] SC_CTRL   = 8'h1D;
   localparam logic [7:0] SC_ALT    = 8'h38;
   localparam logic [7:0] SC_DEL    = 8'h53;

   // characters
   localparam logic [6:0] CH_LOWER_A  = 7'h61;
   localparam logic [6:0] CH_LOWER_Z  = 7'h7A;
   localparam logic [6:0] CH_UPPER_A  = 7'h41;
   localparam logic [6:0] CH_UPPER_Z  = 7'h5A;
   localparam logic [6:0] CH_LOWER_C  = 7'h63;
   localparam logic [6:0] CH_UPPER_C  = 7'h43;
   localparam logic [6:0] CH_LOWER_D  = 7'h64;
   localparam logic [6:0] CH_UPPER_D  = 7'h44;
   localparam logic [6:0] CH_NEWLINE  = 7'h0A;
   localparam logic [6:0] CH_EOT      = 7'h04;
   localparam logic [6:0] CASE_OFFSET = 7'h20;

   typedef struct packed {
      logic       func;
      logic [7:0] scan_code;
   } scq_req_type;

   typedef struct packed {
      logic [6:0] char_out;
      logic       char_valid;
      logic       queue_empty;
      logic       dropped;
      logic [6:0] fill_count;
   } scq_rsp_type;

   typedef struct packed {
      logic shift_held;
      logic control_held;
      logic alt_held;
      logic caps_on;
      logic extended_prefix;
   } scq_mods_type;

   localparam logic [6:0] PLAIN_MAP [MAP_LEN] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20
   };

   localparam logic [6:0] UPPER_MAP [MAP_LEN] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h00, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20
   };

   // slots past the defined ones read as zero
   function automatic logic [6:0] key_map(input logic shifted, input logic [6:0] code);
      logic [6:0] ch;
      ch = 7'h00;
      if (code < 7'(MAP_LEN)) begin
         ch = shifted ? UPPER_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
      end
      return ch;
   endfunction

endpackage

// ===== src/scq_ring.sv =====
// scq_ring: character ring storage, one write and one registered read port
// depends on nothing but its parameter

module scq_ring #(
   parameter int DEPTH = 64,
   parameter int PTR_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PTR_W-1:0] wr_addr,
   input  logic [6:0]       wr_data,
   input  logic             rd_en,
   input  logic [PTR_W-1:0] rd_addr,
   output logic [6:0]       rd_data
);

   logic [6:0] mem [DEPTH];
   logic [6:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/scq_xlate.sv =====
// scq_xlate: modifier tracking and scan code to character translation
// depends on scq_pkg for the key maps and scan code constants

module scq_xlate #(
   parameter int MAP_ENTRIES = 58
) (
   input  logic [7:0]           scan_code,
   input  scq_pkg::scq_mods_type mods,
   output scq_pkg::scq_mods_type mods_next,
   output logic                 char_make,
   output logic [6:0]           char_code
);
   import scq_pkg::*;

   logic [7:0] code8;
   logic [6:0] raw_char;
   logic [6:0] cased_char;

   assign code8 = {1'b0, scan_code[6:0]};

   always_comb begin
      mods_next = mods;
      char_make = 1'b0;
      if (scan_code == SC_PREFIX) begin
         mods_next.extended_prefix = 1'b1;
      end else if (mods.extended_prefix) begin
         // right alt / right control release or press both clear the flag
         if (code8 == SC_ALT) begin
            mods_next.alt_held = 1'b0;
         end else if (code8 == SC_CTRL) begin
            mods_next.control_held = 1'b0;
         end
         mods_next.extended_prefix = 1'b0;
      end else if (scan_code[7]) begin
         if (code8 == SC_LSHIFT || code8 == SC_RSHIFT) begin
            mods_next.shift_held = 1'b0;
         end
         if (code8 == SC_CTRL) begin
            mods_next.control_held = 1'b0;
         end
         if (code8 == SC_ALT) begin
            mods_next.alt_held = 1'b0;
         end
      end else if (scan_code == SC_ESCKEY) begin
         char_make = 1'b0;
      end else if (scan_code == SC_LSHIFT || scan_code == SC_RSHIFT) begin
         mods_next.shift_held = 1'b1;
      end else if (scan_code == SC_ALT) begin
         mods_next.alt_held = 1'b1;
      end else if (scan_code == SC_CTRL) begin
         mods_next.control_held = 1'b1;
      end else if (scan_code == SC_CAPS) begin
         mods_next.caps_on = ~mods.caps_on;
      end else if (mods.control_held && mods.alt_held && scan_code == SC_DEL) begin
         char_make = 1'b0;
      end else if (scan_code < 8'(MAP_ENTRIES)) begin
         char_make = 1'b1;
      end
   end

   assign raw_char = key_map(mods.shift_held, scan_code[6:0]);

   always_comb begin
      cased_char = raw_char;
      if (mods.caps_on) begin
         if (raw_char >= CH_UPPER_A && raw_char <= CH_UPPER_Z) begin
            cased_char = raw_char + CASE_OFFSET;
         end else if (raw_char >= CH_LOWER_A && raw_char <= CH_LOWER_Z) begin
            cased_char = raw_char - CASE_OFFSET;
         end
      end
      char_code = cased_char;
      if (mods.control_held && (cased_char == CH_LOWER_C || cased_char == CH_UPPER_C)) begin
         char_code = CH_NEWLINE;
      end
      if (mods.control_held && (cased_char == CH_LOWER_D || cased_char == CH_UPPER_D)) begin
         char_code = CH_EOT;
      end
   end

endmodule

// ===== src/scq_outbuf.sv =====
// scq_outbuf: two-entry result buffer (output register plus skid) for the rsp side
// depends on scq_pkg for the result item type

module scq_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  scq_pkg::scq_rsp_type push_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output scq_pkg::scq_rsp_type rsp_data
);
   import scq_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   scq_rsp_type out_data_ff, out_data_in;
   scq_rsp_type skid_data_ff, skid_data_in;
   logic        pop;

   assign pop = out_valid_ff & ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = out_valid_ff & skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== src/scan_code_to_ascii_queue.sv =====
// scan_code_to_ascii_queue: set 1 scan codes to ASCII with a character ring
// depends on scq_pkg, scq_xlate, scq_ring and scq_outbuf

// Takes one item per clock cycle when the result side keeps up. A scan code
// item updates the shift, control, alt, capslock and prefix flags and may
// push one character into the ring; a read item pops the oldest character.
// Every item gives one result, through the read stage, which waits on the
// ring's registered read port, and then the result buffer. The item rate
// is set by the flag and pointer update, done in the accept cycle, and by
// the ring's single write and single read port. The ring is not cleared
// after reset; only written entries are ever read. req_stall rises only
// when the two-entry result buffer and the read stage are all occupied.

module scan_code_to_ascii_queue #(
   parameter int RING_DEPTH  = scq_pkg::RING_DEPTH_DEF,
   parameter int MAP_ENTRIES = scq_pkg::MAP_ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  scq_pkg::scq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output scq_pkg::scq_rsp_type rsp_data
);
   import scq_pkg::*;

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);

   scq_mods_type     mods_ff, mods_in, mods_xlate;
   logic [PTR_W-1:0] wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0] rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // read stage, waiting on the ring read data
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_char_valid_ff;
   logic             s1_empty_ff;
   logic             s1_dropped_ff;
   logic [CNT_W-1:0] s1_count_ff;

   logic             accept;
   logic             buf_full;
   logic             s1_push;
   logic             char_make;
   logic [6:0]       char_code;
   logic             ring_full;
   logic             ring_empty;
   logic             do_write;
   logic             do_read;
   logic             is_read;
   logic [6:0]       rd_char;
   scq_rsp_type      s1_rsp;

   assign req_stall = s1_valid_ff & buf_full;
   assign accept    = req_valid & ~req_stall;
   assign s1_push   = s1_valid_ff & ~buf_full;
   assign is_read   = (req_data.func == FUNC_READ);

   scq_xlate #(
      .MAP_ENTRIES(MAP_ENTRIES)
   ) u_xlate (
      .scan_code (req_data.scan_code),
      .mods      (mods_ff),
      .mods_next (mods_xlate),
      .char_make (char_make),
      .char_code (char_code)
   );

   assign ring_full  = (count_ff == CNT_W'(RING_DEPTH));
   assign ring_empty = (count_ff == '0);
   assign do_write   = accept & ~is_read & char_make & ~ring_full;
   assign do_read    = accept & is_read & ~ring_empty;

   always_comb begin
      mods_in   = mods_ff;
      wr_pos_in = wr_pos_ff;
      rd_pos_in = rd_pos_ff;
      count_in  = count_ff;
      if (accept && !is_read) begin
         mods_in = mods_xlate;
      end
      if (do_write) begin
         wr_pos_in = (wr_pos_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_pos_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (do_read) begin
         rd_pos_in = (rd_pos_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_pos_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff     <= '0;
         wr_pos_ff   <= '0;
         rd_pos_ff   <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         mods_ff     <= mods_in;
         wr_pos_ff   <= wr_pos_in;
         rd_pos_ff   <= rd_pos_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_char_valid_ff <= do_read;
         s1_empty_ff      <= is_read & ring_empty;
         s1_dropped_ff    <= ~is_read & char_make & ring_full;
         s1_count_ff      <= count_in;
      end
   end

   // a pop never targets the entry written in the same cycle
   scq_ring #(
      .DEPTH(RING_DEPTH),
      .PTR_W(PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (wr_pos_ff),
      .wr_data (char_code),
      .rd_en   (do_read),
      .rd_addr (rd_pos_ff),
      .rd_data (rd_char)
   );

   always_comb begin
      s1_rsp.char_out    = s1_char_valid_ff ? rd_char : 7'h00;
      s1_rsp.char_valid  = s1_char_valid_ff;
      s1_rsp.queue_empty = s1_empty_ff;
      s1_rsp.dropped     = s1_dropped_ff;
      s1_rsp.fill_count  = 7'(s1_count_ff);
   end

   scq_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_push),
      .push_data (s1_rsp),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
